// ----- hdl/crlb_pkg.sv -----
// ----------------------------------------------------------------------------
// CIGAR run-length builder package
// Shared widths, operation and error codes, result item and queue status types.
// ----------------------------------------------------------------------------
package crlb_pkg;

  localparam int FIELD_W      = 16;
  localparam int LEN_BITS_DEF = 16;
  localparam int MAX_RESULTS  = 3;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  // operation characters
  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_X  = 8'h58;

  // operation codes
  localparam logic [3:0] OP_M   = 4'd0;
  localparam logic [3:0] OP_I   = 4'd1;
  localparam logic [3:0] OP_D   = 4'd2;
  localparam logic [3:0] OP_N   = 4'd3;
  localparam logic [3:0] OP_S   = 4'd4;
  localparam logic [3:0] OP_H   = 4'd5;
  localparam logic [3:0] OP_P   = 4'd6;
  localparam logic [3:0] OP_EQ  = 4'd7;
  localparam logic [3:0] OP_X   = 4'd8;
  localparam logic [3:0] OP_INV = 4'd9;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SAT     = 2'd1;
  localparam logic [1:0] ERR_OVERRUN = 2'd2;

  localparam logic KIND_OP      = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_SKIP = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         op_code;
    logic [FIELD_W-1:0] run_length;
    logic [FIELD_W-1:0] position_adjust;
    logic [FIELD_W-1:0] reference_length;
    logic [FIELD_W-1:0] aligned_query_length;
    logic [FIELD_W-1:0] start_clips;
    logic [FIELD_W-1:0] start_hard_clips;
    logic [FIELD_W-1:0] end_clips;
    logic [FIELD_W-1:0] end_hard_clips;
    logic [1:0]         error;
    logic               last;
  } crlb_result_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  room;
  } crlb_fifo_stat_t;

  function automatic logic [3:0] char_code(input logic [7:0] c);
    logic [3:0] code;
    begin
      case (c)
        CH_M:    code = OP_M;
        CH_I:    code = OP_I;
        CH_D:    code = OP_D;
        CH_N:    code = OP_N;
        CH_S:    code = OP_S;
        CH_H:    code = OP_H;
        CH_P:    code = OP_P;
        CH_EQ:   code = OP_EQ;
        CH_X:    code = OP_X;
        default: code = OP_INV;
      endcase
      return code;
    end
  endfunction

endpackage

// ----- hdl/cigar_run_length_builder.sv -----
// ----------------------------------------------------------------------------
// CIGAR run-length builder
// Streams per-base operation characters and emits CIGAR operation runs
// followed by one end-of-read summary per read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one operation character per transaction, with the
//   soft clip count (used on a read's first character) and a last flag.
//   Result channel (out_*): operation runs (kind 0) and, after each read's
//   last character, a summary (kind 1, last 1).
//   cfg_wr_en/cfg_wr_data set the soft-clip-as-hard mode; write it only
//   while no read is in flight.
//   Path: the input register takes a transaction when it is accepted, the
//   step logic then queues its results once the queue has room, and
//   out_valid rises when the queue holds them.
//   Throughput: one input transaction per cycle while each produces at most
//   one result and out_stall is low; a character can produce up to three
//   results (closing run, final run, summary), and the single result port
//   drains them at one per cycle from a four-entry result queue.
//   Reset (rst_n low, synchronous) returns the read state, the mode and the
//   queue to empty; the block is ready as soon as reset is released.
//   When out_stall holds, results wait in the queue; once the queue has no
//   room for the next character's results, in_stall rises.
// ----------------------------------------------------------------------------
module cigar_run_length_builder #(
  parameter int LEN_BITS = crlb_pkg::LEN_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_op_char,
  input  logic [crlb_pkg::FIELD_W-1:0]     in_soft_clip_start,
  input  logic                             in_last_char,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_kind,
  output logic [3:0]                       out_op_code,
  output logic [crlb_pkg::FIELD_W-1:0]     out_run_length,
  output logic [crlb_pkg::FIELD_W-1:0]     out_position_adjust,
  output logic [crlb_pkg::FIELD_W-1:0]     out_reference_length,
  output logic [crlb_pkg::FIELD_W-1:0]     out_aligned_query_length,
  output logic [crlb_pkg::FIELD_W-1:0]     out_start_clips,
  output logic [crlb_pkg::FIELD_W-1:0]     out_start_hard_clips,
  output logic [crlb_pkg::FIELD_W-1:0]     out_end_clips,
  output logic [crlb_pkg::FIELD_W-1:0]     out_end_hard_clips,
  output logic [1:0]                       out_error,
  output logic                             out_last
);
  import crlb_pkg::*;

  logic                 hard_mode_r;
  logic                 in_valid_r, in_valid_nxt;
  logic [7:0]           op_char_r;
  logic [FIELD_W-1:0]   soft_clip_start_r;
  logic                 last_char_r;
  logic                 in_accept;
  logic                 step_en;

  crlb_result_t [MAX_RESULTS-1:0] step_res;
  logic [RES_CNT_W-1:0]           step_cnt;
  crlb_result_t                   head;
  crlb_fifo_stat_t                fifo_stat;

  assign step_en   = in_valid_r && fifo_stat.room;
  assign in_stall  = in_valid_r && !fifo_stat.room;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_mode_r <= 1'b0;
      in_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hard_mode_r <= cfg_wr_data;
      end
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_char_r         <= in_op_char;
      soft_clip_start_r <= in_soft_clip_start;
      last_char_r       <= in_last_char;
    end
  end

  crlb_step #(
    .LEN_BITS(LEN_BITS)
  ) u_step (
    .clk             (clk),
    .rst_n           (rst_n),
    .hard_mode       (hard_mode_r),
    .en              (step_en),
    .op_char         (op_char_r),
    .soft_clip_start (soft_clip_start_r),
    .last_char       (last_char_r),
    .res             (step_res),
    .res_cnt         (step_cnt)
  );

  crlb_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step_en),
    .push_items (step_res),
    .push_cnt   (step_cnt),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_item   (head),
    .stat       (fifo_stat)
  );

  assign out_kind                 = head.kind;
  assign out_op_code              = head.op_code;
  assign out_run_length           = head.run_length;
  assign out_position_adjust      = head.position_adjust;
  assign out_reference_length     = head.reference_length;
  assign out_aligned_query_length = head.aligned_query_length;
  assign out_start_clips          = head.start_clips;
  assign out_start_hard_clips     = head.start_hard_clips;
  assign out_end_clips            = head.end_clips;
  assign out_end_hard_clips       = head.end_hard_clips;
  assign out_error                = head.error;
  assign out_last                 = head.last;

  a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_last_has_summary : assert property (@(posedge clk) disable iff (!rst_n)
    step_en && last_char_r |-> step_cnt != '0)
    else $error("last character produced no summary");

  a_summary_offered : assert property (@(posedge clk) disable iff (!rst_n)
    step_en && last_char_r |=> out_valid)
    else $error("no result offered after end of read");

  a_empty_no_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

endmodule

// ----- hdl/crlb_step.sv -----
// ----------------------------------------------------------------------------
// CIGAR run-length builder step
// Per-read state and the single-pass logic that turns one registered
// character into zero to three result items.
// ----------------------------------------------------------------------------
module crlb_step #(
  parameter int LEN_BITS = crlb_pkg::LEN_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        hard_mode,
  input  logic                                        en,
  input  logic [7:0]                                  op_char,
  input  logic [crlb_pkg::FIELD_W-1:0]                soft_clip_start,
  input  logic                                        last_char,
  output crlb_pkg::crlb_result_t [crlb_pkg::MAX_RESULTS-1:0] res,
  output logic [crlb_pkg::RES_CNT_W-1:0]              res_cnt
);
  import crlb_pkg::*;

  localparam logic [32:0] LEN_LIMIT = (33'd1 << LEN_BITS) - 33'd1;

  typedef struct packed {
    logic [LEN_BITS-1:0] ref_sum;
    logic [LEN_BITS-1:0] query_sum;
    logic [LEN_BITS-1:0] start_sum;
    logic [LEN_BITS-1:0] start_hard_sum;
    logic [LEN_BITS-1:0] end_sum;
    logic [LEN_BITS-1:0] end_hard_sum;
    logic                in_clip_prefix;
    logic                in_hard_prefix;
    logic [1:0]          err;
  } acc_t;

  localparam acc_t ACC_INIT = '{in_clip_prefix: 1'b1, in_hard_prefix: 1'b1, default: '0};

  phase_t              phase_r, phase_nxt;
  logic [LEN_BITS-1:0] skip_r, skip_nxt;
  logic [LEN_BITS-1:0] clip_r, clip_nxt;
  logic [7:0]          run_char_r, run_char_nxt;
  logic [LEN_BITS-1:0] run_len_r, run_len_nxt;
  logic [LEN_BITS-1:0] adj_r, adj_nxt;
  acc_t                acc_r, acc_nxt;

  // top bit flags saturation, low bits hold the clamped sum
  function automatic logic [LEN_BITS:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                input logic [LEN_BITS-1:0] b);
    logic [LEN_BITS:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s[LEN_BITS]) begin
        s = {1'b1, {LEN_BITS{1'b1}}};
      end
      return s;
    end
  endfunction

  function automatic logic [1:0] mark_sat(input logic [1:0] err, input logic ov);
    return (ov && (err == ERR_NONE)) ? ERR_SAT : err;
  endfunction

  function automatic acc_t acc_op(input acc_t a, input logic [3:0] code,
                                  input logic [LEN_BITS-1:0] len);
    acc_t              r;
    logic              clip;
    logic              hard;
    logic [LEN_BITS:0] s;
    begin
      r    = a;
      clip = (code == OP_S) || (code == OP_H);
      hard = (code == OP_H);
      if ((code == OP_M) || (code == OP_D) || (code == OP_N)) begin
        s = sat_add(r.ref_sum, len);
        r.ref_sum = s[LEN_BITS-1:0];
        r.err = mark_sat(r.err, s[LEN_BITS]);
      end
      if ((code == OP_M) || (code == OP_I)) begin
        s = sat_add(r.query_sum, len);
        r.query_sum = s[LEN_BITS-1:0];
        r.err = mark_sat(r.err, s[LEN_BITS]);
      end
      if (r.in_clip_prefix && clip) begin
        s = sat_add(r.start_sum, len);
        r.start_sum = s[LEN_BITS-1:0];
        r.err = mark_sat(r.err, s[LEN_BITS]);
      end else begin
        r.in_clip_prefix = 1'b0;
      end
      if (r.in_hard_prefix && hard) begin
        s = sat_add(r.start_hard_sum, len);
        r.start_hard_sum = s[LEN_BITS-1:0];
        r.err = mark_sat(r.err, s[LEN_BITS]);
      end else begin
        r.in_hard_prefix = 1'b0;
      end
      if (clip) begin
        s = sat_add(r.end_sum, len);
        r.end_sum = s[LEN_BITS-1:0];
        r.err = mark_sat(r.err, s[LEN_BITS]);
      end else begin
        r.end_sum = '0;
      end
      if (hard) begin
        s = sat_add(r.end_hard_sum, len);
        r.end_hard_sum = s[LEN_BITS-1:0];
        r.err = mark_sat(r.err, s[LEN_BITS]);
      end else begin
        r.end_hard_sum = '0;
      end
      return r;
    end
  endfunction

  function automatic crlb_result_t op_item(input logic [3:0] code,
                                           input logic [LEN_BITS-1:0] len);
    crlb_result_t r;
    begin
      r            = '0;
      r.kind       = KIND_OP;
      r.op_code    = code;
      r.run_length = FIELD_W'(len);
      return r;
    end
  endfunction

  function automatic logic [3:0] emit_code(input logic [3:0] code, input logic hard);
    return ((code == OP_S) && hard) ? OP_H : code;
  endfunction

  logic                  clamp;
  logic [LEN_BITS-1:0]   clip_in;
  logic                  do_run;
  logic [LEN_BITS:0]     s;
  logic [3:0]            code;
  logic [RES_CNT_W-1:0]  n;
  crlb_result_t [MAX_RESULTS-1:0] items;

  assign clamp   = 33'(soft_clip_start) > LEN_LIMIT;
  assign clip_in = clamp ? {LEN_BITS{1'b1}} : LEN_BITS'(soft_clip_start);

  always_comb begin
    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    clip_nxt     = clip_r;
    run_char_nxt = run_char_r;
    run_len_nxt  = run_len_r;
    adj_nxt      = adj_r;
    acc_nxt      = acc_r;
    items        = '0;
    n            = '0;
    do_run       = 1'b0;
    s            = '0;
    code         = OP_INV;

    case (phase_r)
      PH_LEAD: begin
        // first item of a read samples the clip count
        if (adj_r == '0) begin
          clip_nxt    = clip_in;
          acc_nxt.err = mark_sat(acc_nxt.err, clamp);
        end
        if (op_char == CH_N) begin
          s           = sat_add(adj_r, LEN_BITS'(1));
          adj_nxt     = s[LEN_BITS-1:0];
          acc_nxt.err = mark_sat(acc_nxt.err, s[LEN_BITS]);
        end else if (clip_nxt != '0) begin
          code     = emit_code(OP_S, hard_mode);
          acc_nxt  = acc_op(acc_nxt, code, clip_nxt);
          items[n] = op_item(code, clip_nxt);
          n        = n + RES_CNT_W'(1);
          skip_nxt = clip_nxt - LEN_BITS'(1);
          phase_nxt = (skip_nxt != '0) ? PH_SKIP : PH_RUN;
        end else begin
          phase_nxt = PH_RUN;
          do_run    = 1'b1;
        end
      end
      PH_SKIP: begin
        if (skip_r != '0) begin
          skip_nxt = skip_r - LEN_BITS'(1);
          if (skip_nxt == '0) begin
            phase_nxt = PH_RUN;
          end
        end else begin
          phase_nxt = PH_RUN;
          do_run    = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_RUN;
        do_run    = 1'b1;
      end
    endcase

    if (do_run) begin
      if ((run_len_r != '0) && (op_char == run_char_r)) begin
        s           = sat_add(run_len_r, LEN_BITS'(1));
        run_len_nxt = s[LEN_BITS-1:0];
        acc_nxt.err = mark_sat(acc_nxt.err, s[LEN_BITS]);
      end else begin
        // close the open run before starting a new one
        if (run_len_r != '0) begin
          code     = emit_code(char_code(run_char_r), hard_mode);
          acc_nxt  = acc_op(acc_nxt, code, run_len_r);
          items[n] = op_item(code, run_len_r);
          n        = n + RES_CNT_W'(1);
        end
        run_char_nxt = op_char;
        run_len_nxt  = LEN_BITS'(1);
      end
    end

    if (last_char) begin
      if ((phase_nxt == PH_LEAD) && (clip_nxt != '0)) begin
        code        = emit_code(OP_S, hard_mode);
        acc_nxt     = acc_op(acc_nxt, code, clip_nxt);
        items[n]    = op_item(code, clip_nxt);
        n           = n + RES_CNT_W'(1);
        acc_nxt.err = ERR_OVERRUN;
      end
      if ((phase_nxt == PH_SKIP) && (skip_nxt != '0)) begin
        acc_nxt.err = ERR_OVERRUN;
      end
      if (run_len_nxt != '0) begin
        code     = emit_code(char_code(run_char_nxt), hard_mode);
        acc_nxt  = acc_op(acc_nxt, code, run_len_nxt);
        items[n] = op_item(code, run_len_nxt);
        n        = n + RES_CNT_W'(1);
      end
      s           = sat_add(adj_nxt, clip_nxt);
      acc_nxt.err = mark_sat(acc_nxt.err, s[LEN_BITS]);
      items[n]                      = '0;
      items[n].kind                 = KIND_SUMMARY;
      items[n].position_adjust      = FIELD_W'(s[LEN_BITS-1:0]);
      items[n].reference_length     = FIELD_W'(acc_nxt.ref_sum);
      items[n].aligned_query_length = FIELD_W'(acc_nxt.query_sum);
      items[n].start_clips          = FIELD_W'(acc_nxt.start_sum);
      items[n].start_hard_clips     = FIELD_W'(acc_nxt.start_hard_sum);
      items[n].end_clips            = FIELD_W'(acc_nxt.end_sum);
      items[n].end_hard_clips       = FIELD_W'(acc_nxt.end_hard_sum);
      items[n].error                = acc_nxt.err;
      items[n].last                 = 1'b1;
      n = n + RES_CNT_W'(1);

      // return to the start-of-read state
      phase_nxt    = PH_LEAD;
      skip_nxt     = '0;
      clip_nxt     = '0;
      run_char_nxt = '0;
      run_len_nxt  = '0;
      adj_nxt      = '0;
      acc_nxt      = '0;
      acc_nxt.in_clip_prefix = 1'b1;
      acc_nxt.in_hard_prefix = 1'b1;
    end
  end

  assign res     = items;
  assign res_cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEAD;
      skip_r     <= '0;
      clip_r     <= '0;
      run_char_r <= '0;
      run_len_r  <= '0;
      adj_r      <= '0;
      acc_r      <= ACC_INIT;
    end else if (en) begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      clip_r     <= clip_nxt;
      run_char_r <= run_char_nxt;
      run_len_r  <= run_len_nxt;
      adj_r      <= adj_nxt;
      acc_r      <= acc_nxt;
    end
  end

endmodule

// ----- hdl/crlb_fifo.sv -----
// ----------------------------------------------------------------------------
// CIGAR run-length builder result queue
// Takes up to three result items per cycle and hands them out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module crlb_fifo (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               push,
  input  crlb_pkg::crlb_result_t [crlb_pkg::MAX_RESULTS-1:0] push_items,
  input  logic [crlb_pkg::RES_CNT_W-1:0]                     push_cnt,
  input  logic                                               out_stall,
  output logic                                               out_valid,
  output crlb_pkg::crlb_result_t                             out_item,
  output crlb_pkg::crlb_fifo_stat_t                          stat
);
  import crlb_pkg::*;

  crlb_result_t          mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;
  logic [FIFO_CNT_W:0]   fill_after;

  assign pop        = (cnt_r != '0) && !out_stall;
  // room check counts this cycle's pop so the queue keeps one item a cycle
  assign fill_after = {1'b0, cnt_r} - (FIFO_CNT_W + 1)'(pop)
                      + (FIFO_CNT_W + 1)'(push_cnt);

  assign stat.count = cnt_r;
  assign stat.room  = fill_after <= (FIFO_CNT_W + 1)'(FIFO_DEPTH);

  assign out_valid = cnt_r != '0;
  assign out_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_cnt);
      cnt_nxt    = cnt_nxt + FIFO_CNT_W'(push_cnt);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(1);
      cnt_nxt    = cnt_nxt - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push && (RES_CNT_W'(i) < push_cnt)) begin
        mem[wr_ptr_r + FIFO_PTR_W'(i)] <= push_items[i];
      end
    end
  end

endmodule

// ----- sim/cigar_run_length_builder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CIGAR run-length builder testbench
// Streams reads of operation characters through the block under random idle
// and stall, predicts every operation run and end-of-read summary, and checks
// each result transaction field by field in order.
// ----------------------------------------------------------------------------
module cigar_run_length_builder_tb;
  import crlb_pkg::*;

  class cigar_scoreboard;
    localparam int unsigned LEN_MAX = (1 << LEN_BITS_DEF) - 1;

    bit           hard_mode;
    int unsigned  fail_count;
    crlb_result_t cigar_q[$];

    phase_t       stage;
    int unsigned  skip_cnt;
    int unsigned  clip_len;
    logic [7:0]   cur_char;
    int unsigned  cur_len;
    int unsigned  adj_cnt;
    int unsigned  ref_total;
    int unsigned  qry_total;
    int unsigned  lead_clip;
    int unsigned  lead_hard;
    bit           in_lead_clip;
    bit           in_lead_hard;
    int unsigned  tail_clip;
    int unsigned  tail_hard;
    logic [1:0]   err;

    function new();
      hard_mode  = 1'b0;
      fail_count = 0;
      restart();
    endfunction

    function void restart();
      stage        = PH_LEAD;
      skip_cnt     = 0;
      clip_len     = 0;
      cur_char     = 8'h00;
      cur_len      = 0;
      adj_cnt      = 0;
      ref_total    = 0;
      qry_total    = 0;
      lead_clip    = 0;
      lead_hard    = 0;
      in_lead_clip = 1'b1;
      in_lead_hard = 1'b1;
      tail_clip    = 0;
      tail_hard    = 0;
      err          = ERR_NONE;
    endfunction

    function int pending();
      return cigar_q.size();
    endfunction

    function int unsigned sat_add(int unsigned a, int unsigned b);
      longint unsigned s;
      s = 64'(a);
      s = s + 64'(b);
      if (s > 64'(LEN_MAX)) begin
        if (err == ERR_NONE) err = ERR_SAT;
        return LEN_MAX;
      end
      return s[31:0];
    endfunction

    function logic [3:0] code_of(logic [7:0] c);
      case (c)
        CH_M:    return OP_M;
        CH_I:    return OP_I;
        CH_D:    return OP_D;
        CH_N:    return OP_N;
        CH_S:    return OP_S;
        CH_H:    return OP_H;
        CH_P:    return OP_P;
        CH_EQ:   return OP_EQ;
        CH_X:    return OP_X;
        default: return OP_INV;
      endcase
    endfunction

    function void emit_op(logic [3:0] code, int unsigned len);
      crlb_result_t r;
      bit clip;
      bit hard;
      if (code == OP_S && hard_mode) code = OP_H;
      clip = (code == OP_S) || (code == OP_H);
      hard = (code == OP_H);
      if (code == OP_M || code == OP_D || code == OP_N) ref_total = sat_add(ref_total, len);
      if (code == OP_M || code == OP_I) qry_total = sat_add(qry_total, len);
      if (in_lead_clip && clip) lead_clip = sat_add(lead_clip, len);
      else in_lead_clip = 1'b0;
      if (in_lead_hard && hard) lead_hard = sat_add(lead_hard, len);
      else in_lead_hard = 1'b0;
      tail_clip = clip ? sat_add(tail_clip, len) : 0;
      tail_hard = hard ? sat_add(tail_hard, len) : 0;
      r = '0;
      r.kind       = KIND_OP;
      r.op_code    = code;
      r.run_length = len[FIELD_W-1:0];
      cigar_q.push_back(r);
    endfunction

    function void emit_summary();
      crlb_result_t r;
      int unsigned adj;
      adj = sat_add(adj_cnt, clip_len);
      r = '0;
      r.kind                 = KIND_SUMMARY;
      r.position_adjust      = adj[FIELD_W-1:0];
      r.reference_length     = ref_total[FIELD_W-1:0];
      r.aligned_query_length = qry_total[FIELD_W-1:0];
      r.start_clips          = lead_clip[FIELD_W-1:0];
      r.start_hard_clips     = lead_hard[FIELD_W-1:0];
      r.end_clips            = tail_clip[FIELD_W-1:0];
      r.end_hard_clips       = tail_hard[FIELD_W-1:0];
      r.error                = err;
      r.last                 = 1'b1;
      cigar_q.push_back(r);
    endfunction

    function void extend_run(logic [7:0] c);
      if (cur_len > 0 && c == cur_char) begin
        cur_len = sat_add(cur_len, 1);
        return;
      end
      if (cur_len > 0) emit_op(code_of(cur_char), cur_len);
      cur_char = c;
      cur_len  = 1;
    endfunction

    // Advance the read state by one accepted character and queue its results.
    function void note_char(logic [7:0] c, logic [FIELD_W-1:0] clip_in, logic fin);
      int unsigned clip_v;
      clip_v = 32'(clip_in);
      if (stage == PH_LEAD) begin
        // first character of a read: sample the clip request
        if (adj_cnt == 0) begin
          if (clip_v > LEN_MAX) begin
            clip_v = LEN_MAX;
            if (err == ERR_NONE) err = ERR_SAT;
          end
          clip_len = clip_v;
        end
        if (c == CH_N) begin
          adj_cnt = sat_add(adj_cnt, 1);
        end else if (clip_len > 0) begin
          emit_op(OP_S, clip_len);
          skip_cnt = clip_len - 1;
          stage = (skip_cnt > 0) ? PH_SKIP : PH_RUN;
        end else begin
          stage = PH_RUN;
          extend_run(c);
        end
      end else if (stage == PH_SKIP && skip_cnt > 0) begin
        skip_cnt--;
        if (skip_cnt == 0) stage = PH_RUN;
      end else begin
        stage = PH_RUN;
        extend_run(c);
      end

      if (fin) begin
        // clip requested but never reached, or not fully skipped
        if (stage == PH_LEAD && clip_len > 0) begin
          emit_op(OP_S, clip_len);
          err = ERR_OVERRUN;
        end
        if (stage == PH_SKIP && skip_cnt > 0) err = ERR_OVERRUN;
        if (cur_len > 0) emit_op(code_of(cur_char), cur_len);
        emit_summary();
        restart();
      end
    endfunction

    function void compare(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, actual %0d", name, want_v, got_v);
        fail_count++;
      end
    endfunction

    function void check_result(crlb_result_t got);
      crlb_result_t want;
      if (cigar_q.size() == 0) begin
        $error("result transaction with no expected item pending");
        fail_count++;
        return;
      end
      want = cigar_q.pop_front();
      compare("kind", 32'(want.kind), 32'(got.kind));
      compare("op_code", 32'(want.op_code), 32'(got.op_code));
      compare("run_length", 32'(want.run_length), 32'(got.run_length));
      compare("position_adjust", 32'(want.position_adjust), 32'(got.position_adjust));
      compare("reference_length", 32'(want.reference_length),
              32'(got.reference_length));
      compare("aligned_query_length", 32'(want.aligned_query_length),
              32'(got.aligned_query_length));
      compare("start_clips", 32'(want.start_clips), 32'(got.start_clips));
      compare("start_hard_clips", 32'(want.start_hard_clips),
              32'(got.start_hard_clips));
      compare("end_clips", 32'(want.end_clips), 32'(got.end_clips));
      compare("end_hard_clips", 32'(want.end_hard_clips), 32'(got.end_hard_clips));
      compare("error", 32'(want.error), 32'(got.error));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 56;

  localparam logic [7:0] OP_CHARS [9] = '{CH_M, CH_I, CH_D, CH_N, CH_S, CH_H, CH_P, CH_EQ, CH_X};

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               cfg_wr_en          = 1'b0;
  logic               cfg_wr_data        = 1'b0;
  logic               in_valid           = 1'b0;
  logic [7:0]         in_op_char         = 8'h00;
  logic [FIELD_W-1:0] in_soft_clip_start = '0;
  logic               in_last_char       = 1'b0;
  logic               out_stall          = 1'b0;

  logic               in_stall;
  logic               out_valid;
  logic               out_kind;
  logic [3:0]         out_op_code;
  logic [FIELD_W-1:0] out_run_length;
  logic [FIELD_W-1:0] out_position_adjust;
  logic [FIELD_W-1:0] out_reference_length;
  logic [FIELD_W-1:0] out_aligned_query_length;
  logic [FIELD_W-1:0] out_start_clips;
  logic [FIELD_W-1:0] out_start_hard_clips;
  logic [FIELD_W-1:0] out_end_clips;
  logic [FIELD_W-1:0] out_end_hard_clips;
  logic [1:0]         out_error;
  logic               out_last;

  cigar_scoreboard sb = new();
  crlb_result_t    seen;
  bit              idle_on    = 1'b1;
  bit              hold_req   = 1'b0;
  int unsigned     items_sent = 0;
  int unsigned     quiet_cycles = 0;

  always #5 clk = ~clk;

  cigar_run_length_builder dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_wr_en                (cfg_wr_en),
    .cfg_wr_data              (cfg_wr_data),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_op_char               (in_op_char),
    .in_soft_clip_start       (in_soft_clip_start),
    .in_last_char             (in_last_char),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_kind                 (out_kind),
    .out_op_code              (out_op_code),
    .out_run_length           (out_run_length),
    .out_position_adjust      (out_position_adjust),
    .out_reference_length     (out_reference_length),
    .out_aligned_query_length (out_aligned_query_length),
    .out_start_clips          (out_start_clips),
    .out_start_hard_clips     (out_start_hard_clips),
    .out_end_clips            (out_end_clips),
    .out_end_hard_clips       (out_end_hard_clips),
    .out_error                (out_error),
    .out_last                 (out_last)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] c, input logic [FIELD_W-1:0] clip,
                           input logic fin);
    while (idle_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_op_char         <= c;
    in_soft_clip_start <= clip;
    in_last_char       <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_char(c, clip, fin);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input logic [FIELD_W-1:0] clip);
    for (int i = 0; i < s.len(); i++) send_char(s[i], clip, i == s.len() - 1);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input bit hard);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hard;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.hard_mode = hard;
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(99) < 85) return OP_CHARS[$urandom_range(8)];
    return 8'($urandom_range(255));
  endfunction

  task automatic random_read();
    logic [7:0]         body[$];
    logic [7:0]         ch;
    logic [FIELD_W-1:0] clip;
    int                 lead_n;
    int                 len;
    int                 total;
    int                 r;
    lead_n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    len = $urandom_range(1, 12);
    if ($urandom_range(99) < 5) begin
      lead_n = $urandom_range(1, 3);
      len = 0;
    end
    r = $urandom_range(99);
    if (r < 50) clip = '0;
    else if (r < 85) clip = FIELD_W'($urandom_range(1, 4));
    else if (r < 95) clip = FIELD_W'($urandom_range(0, 65535));
    else clip = '1;
    ch = pick_char();
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(99) < 55) body.push_back(ch);
      else begin
        ch = pick_char();
        body.push_back(ch);
      end
    end
    total = lead_n + len;
    for (int i = 0; i < total; i++) begin
      send_char((i < lead_n) ? CH_N : body[i - lead_n],
                (i == 0) ? clip : FIELD_W'($urandom_range(0, 65535)),
                i == total - 1);
    end
  endtask

  // Receiver: random stall, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= idle_on && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.kind                 = out_kind;
      seen.op_code              = out_op_code;
      seen.run_length           = out_run_length;
      seen.position_adjust      = out_position_adjust;
      seen.reference_length     = out_reference_length;
      seen.aligned_query_length = out_aligned_query_length;
      seen.start_clips          = out_start_clips;
      seen.start_hard_clips     = out_start_hard_clips;
      seen.end_clips            = out_end_clips;
      seen.end_hard_clips       = out_end_hard_clips;
      seen.error                = out_error;
      seen.last                 = out_last;
      sb.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_mode(1'b0);

    // directed reads
    send_string("M", 16'd0);
    send_string("NN", 16'd0);                  // only leading N, no clip
    send_string("NN", 16'd3);                  // clip requested, read ends in leading N
    send_string("MIDDNX", 16'd2);              // clip, skip, then runs
    send_string("MM", 16'd5);                  // clip overruns the read
    send_string("HSMSH", 16'd0);               // leading and trailing clip runs
    send_char(8'h00, 16'd0, 1'b0);             // distinct unknown bytes
    send_char(8'hFF, 16'hFFFF, 1'b0);
    send_char(8'hFF, 16'd0, 1'b0);
    send_char(CH_P, 16'd0, 1'b0);
    send_char(CH_EQ, 16'd0, 1'b1);
    send_string("M", 16'hFFFF);                // largest clip, overrun
    wait_idle();
    write_mode(1'b1);
    send_string("MSS", 16'd1);                 // soft clips come out hard

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_mode((ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(1)));
      idle_on = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_read();
    end
    idle_on = 1'b1;

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
